@@ rtl/mtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mtt_pkg
// Types and codes shared by the markup tag tokenizer modules.
// ----------------------------------------------------------------------------
package mtt_pkg;

	typedef enum logic [1:0] {
		KIND_TEXT    = 2'd0,
		KIND_RUN_END = 2'd1,
		KIND_TAG     = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CODE_HTML    = 3'd0,
		CODE_HEAD    = 3'd1,
		CODE_TITLE   = 3'd2,
		CODE_BODY    = 3'd3,
		CODE_P       = 3'd4,
		CODE_BR      = 3'd5,
		CODE_HEADING = 3'd6
	} tag_t;

	typedef enum logic [1:0] {
		ERR_FIRST  = 2'd0,
		ERR_SECOND = 2'd1,
		ERR_NAME   = 2'd2
	} err_t;

	// Literal states run in consecutive codes so a match advances by one.
	typedef enum logic [4:0] {
		ST_TOP      = 5'd0,
		ST_TEXT     = 5'd1,
		ST_FIRST    = 5'd2,
		ST_H        = 5'd3,
		ST_T        = 5'd4,
		ST_B        = 5'd5,
		ST_HTML_M   = 5'd6,
		ST_HTML_L   = 5'd7,
		ST_HTML_GT  = 5'd8,
		ST_HEAD_A   = 5'd9,
		ST_HEAD_D   = 5'd10,
		ST_HEAD_GT  = 5'd11,
		ST_TITLE_T  = 5'd12,
		ST_TITLE_L  = 5'd13,
		ST_TITLE_E  = 5'd14,
		ST_TITLE_GT = 5'd15,
		ST_BODY_D   = 5'd16,
		ST_BODY_Y   = 5'd17,
		ST_BODY_GT  = 5'd18,
		ST_P_GT     = 5'd19,
		ST_BR_GT    = 5'd20,
		ST_HNUM_GT  = 5'd21
	} state_t;

	typedef struct packed {
		logic [7:0] ch;
	} in_word_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] text_byte;
		tag_t       tag_code;
		logic       closing;
		err_t       error_code;
	} out_word_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} step_res_t;

endpackage

@@ rtl/mtt_stream_if.sv @@
// ----------------------------------------------------------------------------
// mtt_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface mtt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/markup_tag_tokenizer.sv @@
// ----------------------------------------------------------------------------
// markup_tag_tokenizer
// Byte-stream tokenizer for a small markup subset: text runs and tags.
// ----------------------------------------------------------------------------
//  channel | modport | payload          | word
//  text    | sink    | ch               | one byte of markup text
//  token   | source  | kind, text_byte, | one text byte, run end, tag or error
//          |         | tag_code, closing, error_code
//
//  One byte per cycle while the sink keeps up; a byte is registered in the
//  input register, stepped through the recognizer when that register advances,
//  and its result (if any) is then registered in the output register.
//  Reset returns the recognizer to top level and clears the halt flag.
//  A stalled output register holds its word while the input register keeps
//  its byte; both drain at full rate once the sink takes the word.
// ----------------------------------------------------------------------------
module markup_tag_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	mtt_stream_if.sink          text,
	mtt_stream_if.source        token
);
	import mtt_pkg::*;

	logic       v_s1;
	logic [7:0] ch_s1;
	logic       v_s2;
	out_word_t  word_s2;
	logic       adv_s1;
	step_res_t  res;

	assign adv_s1     = v_s1 && (!v_s2 || token.ready);
	assign text.ready = !v_s1 || adv_s1;

	mtt_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.ch     (ch_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (text.ready) v_s1 <= text.valid;
			if (adv_s1)           v_s2 <= res.valid;
			else if (token.ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) ch_s1 <= text.payload.ch;
		if (adv_s1) word_s2 <= res.word;
	end

	assign token.valid   = v_s2;
	assign token.payload = word_s2;

endmodule

@@ rtl/mtt_fsm.sv @@
// ----------------------------------------------------------------------------
// mtt_fsm
// Recognizer state, closing flag and halt flag; forms the result of one byte.
// ----------------------------------------------------------------------------
module mtt_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	output mtt_pkg::step_res_t res
);
	import mtt_pkg::*;

	state_t state_q, state_d;
	logic   closing_q, closing_d;
	logic   stopped_q, stopped_d;

	function automatic logic [7:0] lit_want(input state_t s);
		logic [7:0] w;
		unique case (s)
			ST_HTML_M:  w = "m";
			ST_HTML_L:  w = "l";
			ST_HEAD_A:  w = "a";
			ST_HEAD_D:  w = "d";
			ST_TITLE_T: w = "t";
			ST_TITLE_L: w = "l";
			ST_TITLE_E: w = "e";
			ST_BODY_D:  w = "d";
			ST_BODY_Y:  w = "y";
			default:    w = ">";
		endcase
		return w;
	endfunction

	function automatic tag_t lit_tag(input state_t s);
		tag_t t;
		unique case (s) inside
			ST_HTML_M, ST_HTML_L, ST_HTML_GT:                t = CODE_HTML;
			ST_HEAD_A, ST_HEAD_D, ST_HEAD_GT:                t = CODE_HEAD;
			ST_TITLE_T, ST_TITLE_L, ST_TITLE_E, ST_TITLE_GT: t = CODE_TITLE;
			ST_BODY_D, ST_BODY_Y, ST_BODY_GT:                t = CODE_BODY;
			ST_P_GT:                                         t = CODE_P;
			ST_BR_GT:                                        t = CODE_BR;
			default:                                         t = CODE_HEADING;
		endcase
		return t;
	endfunction

	logic is_lit, lit_last, lit_hit, is_digit, is_gap;

	always_comb begin
		is_lit   = (state_q >= ST_HTML_M) && (state_q <= ST_HNUM_GT);
		lit_last = (state_q inside {ST_HTML_GT, ST_HEAD_GT, ST_TITLE_GT, ST_BODY_GT,
		                            ST_P_GT, ST_BR_GT, ST_HNUM_GT});
		lit_hit  = (ch == lit_want(state_q));
		is_digit = (ch >= 8'd49) && (ch <= 8'd57);
		is_gap   = (ch == " ") || (ch == 8'h0A);
	end

	// Next state
	always_comb begin
		state_d   = state_q;
		closing_d = closing_q;
		stopped_d = stopped_q;
		if (!stopped_q) begin
			unique case (state_q)
				ST_TEXT: begin
					if (ch == "<") state_d = ST_FIRST;
				end
				ST_FIRST: begin
					if (ch == "h")                    state_d = ST_H;
					else if (ch == "t")               state_d = ST_T;
					else if (ch == "b")               state_d = ST_B;
					else if (ch == "p")               state_d = ST_P_GT;
					else if (ch == "/" && !closing_q) closing_d = 1'b1;
					else                              stopped_d = 1'b1;
				end
				ST_H: begin
					if (is_digit)       state_d = ST_HNUM_GT;
					else if (ch == "e") state_d = ST_HEAD_A;
					else if (ch == "t") state_d = ST_HTML_M;
					else                stopped_d = 1'b1;
				end
				ST_T: begin
					if (ch == "i") state_d = ST_TITLE_T;
					else           stopped_d = 1'b1;
				end
				ST_B: begin
					if (ch == "o")      state_d = ST_BODY_D;
					else if (ch == "r") state_d = ST_BR_GT;
					else                stopped_d = 1'b1;
				end
				default: begin
					if (is_lit) begin
						if (!lit_hit) begin
							stopped_d = 1'b1;
						end else if (lit_last) begin
							state_d   = ST_TOP;
							closing_d = 1'b0;
						end else begin
							state_d = state_t'(state_q + 5'd1);
						end
					end else begin
						// top level, and any code that is never reached
						if (is_gap)         state_d = ST_TOP;
						else if (ch == "<") state_d = ST_FIRST;
						else                state_d = ST_TEXT;
					end
				end
			endcase
		end
	end

	// Result
	always_comb begin
		res = '0;
		if (!stopped_q) begin
			unique case (state_q) inside
				ST_TEXT: begin
					res.valid = 1'b1;
					if (ch == "<") begin
						res.word.kind = KIND_RUN_END;
					end else begin
						res.word.kind      = KIND_TEXT;
						res.word.text_byte = ch;
					end
				end
				ST_FIRST: begin
					if (!(ch == "h" || ch == "t" || ch == "b" || ch == "p" ||
					      (ch == "/" && !closing_q))) begin
						res.valid           = 1'b1;
						res.word.kind       = KIND_ERROR;
						res.word.error_code = ERR_FIRST;
					end
				end
				ST_H, ST_T, ST_B: begin
					if (stopped_d) begin
						res.valid           = 1'b1;
						res.word.kind       = KIND_ERROR;
						res.word.error_code = ERR_SECOND;
					end
				end
				default: begin
					if (is_lit) begin
						if (!lit_hit) begin
							res.valid           = 1'b1;
							res.word.kind       = KIND_ERROR;
							res.word.error_code = ERR_NAME;
						end else if (lit_last) begin
							res.valid         = 1'b1;
							res.word.kind     = KIND_TAG;
							res.word.tag_code = lit_tag(state_q);
							res.word.closing  = closing_q;
						end
					end else if (!is_gap && ch != "<") begin
						res.valid          = 1'b1;
						res.word.kind      = KIND_TEXT;
						res.word.text_byte = ch;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_TOP;
			closing_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (step) begin
			state_q   <= state_d;
			closing_q <= closing_d;
			stopped_q <= stopped_d;
		end
	end

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halt flag cleared without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !res.valid)
		else $error("result formed while halted");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.word.kind == KIND_ERROR) |=> stopped_q)
		else $error("error result did not halt the recognizer");

	a_tag_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && res.word.kind == KIND_TAG) |=>
		(state_q == ST_TOP && !closing_q))
		else $error("completed tag left recognizer inside a tag");

endmodule
